### design/multiplexed_seven_segment_scanner_top_assert.svh
// Assertion macros used by the checker of the seven-segment scanner.
`ifndef MULTIPLEXED_SEVEN_SEGMENT_SCANNER_TOP_ASSERT_SVH
`define MULTIPLEXED_SEVEN_SEGMENT_SCANNER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk and off while rst_n is low.
`define MSSS_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and off while rst_n is low.
`define MSSS_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/msss_pkg.sv
// Types, constants and glyph tables of the seven-segment scanner.
`default_nettype none

package msss_pkg;

    localparam int NUM_DIGITS = 5;
    localparam int REQ_W      = 2;
    localparam int VALUE_W    = 17;
    localparam int SEG_W      = 7;
    localparam int POS_W      = 3;
    localparam int IDX_W      = 3;
    localparam int DIGIT_W    = 4;
    localparam int CODE_W     = 5;
    localparam int RECIP_W    = 31;
    localparam int FRAC_W     = 34;
    localparam int PROD_W     = VALUE_W + RECIP_W;
    localparam int SCALED_W   = FRAC_W + 4;

    localparam logic [VALUE_W-1:0] VALUE_MAX = VALUE_W'(99999);

    localparam logic [REQ_W-1:0] REQ_NUMBER = 2'd0;
    localparam logic [REQ_W-1:0] REQ_OFF    = 2'd1;
    localparam logic [REQ_W-1:0] REQ_BT     = 2'd2;

    localparam logic [CODE_W-1:0] CODE_NONE = 5'd31;
    localparam logic [CODE_W-1:0] CODE_O    = 5'd0;
    localparam logic [CODE_W-1:0] CODE_F    = 5'd15;
    localparam logic [CODE_W-1:0] CODE_8    = 5'd8;
    localparam logic [CODE_W-1:0] CODE_L    = 5'd17;
    localparam logic [CODE_W-1:0] CODE_U    = 5'd18;
    localparam logic [CODE_W-1:0] CODE_E    = 5'd14;

    localparam logic [POS_W-1:0] POS_FIRST = 3'd1;
    localparam logic [POS_W-1:0] POS_LAST  = POS_W'(NUM_DIGITS);

    typedef struct packed {
        logic [REQ_W-1:0]   req_type;
        logic [VALUE_W-1:0] value;
        logic               dot;
    } msss_item_t;

    typedef struct packed {
        logic valid;
        logic advance;
    } msss_ctrl_t;

    function automatic logic pos_active(input logic [POS_W-1:0] pos);
        pos_active = (pos >= POS_FIRST) && (pos <= POS_LAST);
    endfunction

    function automatic logic [IDX_W-1:0] pos_to_idx(input logic [POS_W-1:0] pos);
        pos_to_idx = pos_active(pos) ? IDX_W'(pos - POS_FIRST) : '0;
    endfunction

    // Rounded-up 2^34 / (10 * place value) for each digit position.
    function automatic logic [RECIP_W-1:0] place_recip(input logic [IDX_W-1:0] idx);
        unique case (idx)
            3'd0:    place_recip = 31'd171799;
            3'd1:    place_recip = 31'd1717987;
            3'd2:    place_recip = 31'd17179870;
            3'd3:    place_recip = 31'd171798692;
            3'd4:    place_recip = 31'd1717986919;
            default: place_recip = '0;
        endcase
    endfunction

    function automatic logic [CODE_W-1:0] off_code(input logic [IDX_W-1:0] idx);
        unique case (idx)
            3'd2:    off_code = CODE_O;
            3'd3:    off_code = CODE_F;
            3'd4:    off_code = CODE_F;
            default: off_code = CODE_NONE;
        endcase
    endfunction

    function automatic logic [CODE_W-1:0] bt_code(input logic [IDX_W-1:0] idx);
        unique case (idx)
            3'd1:    bt_code = CODE_8;
            3'd2:    bt_code = CODE_L;
            3'd3:    bt_code = CODE_U;
            3'd4:    bt_code = CODE_E;
            default: bt_code = CODE_NONE;
        endcase
    endfunction

    function automatic logic [SEG_W-1:0] glyph(input logic [CODE_W-1:0] code);
        unique case (code)
            5'd0:    glyph = 7'h3F;
            5'd1:    glyph = 7'h06;
            5'd2:    glyph = 7'h5B;
            5'd3:    glyph = 7'h4F;
            5'd4:    glyph = 7'h66;
            5'd5:    glyph = 7'h6D;
            5'd6:    glyph = 7'h7D;
            5'd7:    glyph = 7'h07;
            5'd8:    glyph = 7'h7F;
            5'd9:    glyph = 7'h6F;
            5'd10:   glyph = 7'h6F;
            5'd11:   glyph = 7'h7F;
            5'd12:   glyph = 7'h79;
            5'd13:   glyph = 7'h3F;
            5'd14:   glyph = 7'h79;
            5'd15:   glyph = 7'h71;
            5'd16:   glyph = 7'h01;
            5'd17:   glyph = 7'h38;
            5'd18:   glyph = 7'h3E;
            default: glyph = 7'h00;
        endcase
    endfunction

endpackage

`default_nettype wire

### design/msss_ifs.sv
// Valid/ready channel interfaces for refresh ticks and digit drive results.
`default_nettype none

interface msss_tick_if
    import msss_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [REQ_W-1:0]   req_type;
    logic [VALUE_W-1:0] value;
    logic               dot;

    modport source (output valid, req_type, value, dot, input ready);
    modport sink   (input valid, req_type, value, dot, output ready);
endinterface

interface msss_drive_if
    import msss_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [NUM_DIGITS-1:0] digit_enable;
    logic [SEG_W-1:0]      segments;
    logic                  point;
    logic                  indicator_off;
    logic                  drive_valid;

    modport source (output valid, digit_enable, segments, point, indicator_off,
                    drive_valid, input ready);
    modport sink   (input valid, digit_enable, segments, point, indicator_off,
                    drive_valid, output ready);
endinterface

`default_nettype wire

### design/msss_in_stage.sv
// Input register that captures one refresh tick per transfer.
`default_nettype none

module msss_in_stage
    import msss_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    msss_tick_if.sink   tick,
    input  wire logic   advance,
    output msss_item_t  item,
    output logic        item_valid
);

    logic       valid_reg;
    logic       valid_next;
    logic       take;
    msss_item_t item_reg;

    assign tick.ready = !valid_reg || advance;
    assign take       = tick.valid && tick.ready;

    always_comb
    begin
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.req_type <= tick.req_type;
            item_reg.value    <= tick.value;
            item_reg.dot      <= tick.dot;
        end
    end

    assign item       = item_reg;
    assign item_valid = valid_reg;

endmodule

`default_nettype wire

### design/msss_digit.sv
// Decimal digit extraction for the scan position by reciprocal multiplication.
`default_nettype none

module msss_digit
    import msss_pkg::*;
(
    input  wire logic [VALUE_W-1:0] value,
    input  wire logic [POS_W-1:0]   pos,
    output logic      [DIGIT_W-1:0] digit
);

    logic [VALUE_W-1:0]  clamped;
    logic [RECIP_W-1:0]  recip;
    logic [PROD_W-1:0]   prod;
    logic [FRAC_W-1:0]   frac;
    logic [SCALED_W-1:0] scaled;

    // The fraction of value / (10 * place) times ten gives the digit.
    always_comb
    begin
        clamped = (value > VALUE_MAX) ? VALUE_MAX : value;
        recip   = place_recip(pos_to_idx(pos));
        prod    = PROD_W'(clamped) * PROD_W'(recip);
        frac    = prod[FRAC_W-1:0];
        scaled  = SCALED_W'({frac, 3'b000}) + SCALED_W'({frac, 1'b0});
        digit   = scaled[SCALED_W-1:FRAC_W];
    end

endmodule

`default_nettype wire

### design/msss_drive.sv
// Scan counter, held display levels and the result register.
`default_nettype none

module msss_drive
    import msss_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire msss_item_t          item,
    input  wire logic [DIGIT_W-1:0]  digit,
    input  wire logic                item_valid,
    output msss_ctrl_t               ctrl,
    output logic      [POS_W-1:0]    pos,
    msss_drive_if.source             drive
);

    logic [POS_W-1:0]      pos_reg;
    logic [POS_W-1:0]      pos_next;
    logic [NUM_DIGITS-1:0] en_reg;
    logic [NUM_DIGITS-1:0] en_next;
    logic [SEG_W-1:0]      seg_reg;
    logic [SEG_W-1:0]      seg_next;
    logic                  pt_reg;
    logic                  pt_next;
    logic                  ind_reg;
    logic                  ind_next;
    logic                  dv_reg;
    logic                  dv_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic                  advance;
    logic                  active;
    logic [IDX_W-1:0]      idx;
    logic [CODE_W-1:0]     code;
    logic [NUM_DIGITS-1:0] en_one;

    assign advance = item_valid && (!out_valid_reg || drive.ready);
    assign active  = pos_active(pos_reg);
    assign idx     = pos_to_idx(pos_reg);
    assign en_one  = NUM_DIGITS'(1) << idx;

    always_comb
    begin
        en_next  = en_reg;
        seg_next = seg_reg;
        pt_next  = pt_reg;
        ind_next = ind_reg;
        code     = CODE_NONE;
        case (item.req_type) inside
            REQ_NUMBER:
            begin
                ind_next = 1'b0;
                if (active)
                begin
                    seg_next = glyph(CODE_W'(digit));
                    pt_next  = (idx == 3'd2) ? item.dot : 1'b0;
                    en_next  = ((idx == 3'd0) && (digit == '0)) ? '0 : en_one;
                end
            end
            REQ_OFF, REQ_BT:
            begin
                if (item.req_type == REQ_BT)
                begin
                    ind_next = 1'b1;
                    code     = bt_code(idx);
                end
                else
                begin
                    code = off_code(idx);
                end
                if (active)
                begin
                    if (code == CODE_NONE)
                    begin
                        en_next = '0;
                    end
                    else
                    begin
                        en_next  = en_one;
                        seg_next = glyph(code);
                        pt_next  = 1'b0;
                    end
                end
            end
            default:
            begin
                en_next = en_reg;
            end
        endcase
        dv_next  = active;
        pos_next = (pos_reg >= POS_LAST) ? POS_FIRST : pos_reg + POS_FIRST;
    end

    always_comb
    begin
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (drive.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            en_reg        <= '0;
            seg_reg       <= '0;
            pt_reg        <= 1'b0;
            ind_reg       <= 1'b0;
            dv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                pos_reg <= pos_next;
                en_reg  <= en_next;
                seg_reg <= seg_next;
                pt_reg  <= pt_next;
                ind_reg <= ind_next;
                dv_reg  <= dv_next;
            end
        end
    end

    assign ctrl.valid          = out_valid_reg;
    assign ctrl.advance        = advance;
    assign pos                 = pos_reg;
    assign drive.valid         = out_valid_reg;
    assign drive.digit_enable  = en_reg;
    assign drive.segments      = seg_reg;
    assign drive.point         = pt_reg;
    assign drive.indicator_off = ind_reg;
    assign drive.drive_valid   = dv_reg;

endmodule

`default_nettype wire

### design/multiplexed_seven_segment_scanner_top.sv
// Top level of the five-digit multiplexed seven-segment scanner.
//
//   Channel  Role    Carries
//   tick     sink    req_type, value, dot: one refresh tick per transfer
//   drive    source  digit_enable, segments, point, indicator_off, drive_valid
//
// One tick is taken per cycle while drive is not stalled.
// The path is the input register, one 17 x 31 reciprocal multiply for the digit,
// the glyph lookup and the held-level register that also serves as output.
// Reset clears the scan position and every held level.
// A stall on drive holds the result and, with the input register full, stops tick.
`default_nettype none

module multiplexed_seven_segment_scanner_top
    import msss_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    msss_tick_if.sink     tick,
    msss_drive_if.source  drive
);

    msss_item_t         item;
    logic               item_valid;
    msss_ctrl_t         ctrl;
    logic [POS_W-1:0]   pos;
    logic [DIGIT_W-1:0] digit;

    msss_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick       (tick),
        .advance    (ctrl.advance),
        .item       (item),
        .item_valid (item_valid)
    );

    msss_digit u_digit (
        .value (item.value),
        .pos   (pos),
        .digit (digit)
    );

    msss_drive u_drive (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .digit      (digit),
        .item_valid (item_valid),
        .ctrl       (ctrl),
        .pos        (pos),
        .drive      (drive)
    );

endmodule

`default_nettype wire

### design/msss_checker.sv
// Port-level checker for the scanner and its bind to the top level.
`default_nettype none

`include "multiplexed_seven_segment_scanner_top_assert.svh"

module msss_checker
    import msss_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  out_valid,
    input wire logic                  out_ready,
    input wire logic [NUM_DIGITS-1:0] digit_enable,
    input wire logic [SEG_W-1:0]      segments,
    input wire logic                  point,
    input wire logic                  drive_valid
);

    `MSSS_ASSERT_NOW(a_one_digit, out_valid, $onehot0(digit_enable), "more than one digit enabled")
    `MSSS_ASSERT_NOW(a_first_tick_dark, out_valid && !drive_valid, digit_enable == '0 && segments == '0 && !point, "first tick drove the display")
    `MSSS_ASSERT_NOW(a_point_digit3, out_valid && point, digit_enable == '0 || digit_enable == 5'b00100, "point lit on a digit other than three")
    `MSSS_ASSERT_NEXT(a_hold_valid, out_valid && !out_ready, out_valid, "result dropped while stalled")

endmodule

bind multiplexed_seven_segment_scanner_top msss_checker u_msss_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (drive.valid),
    .out_ready    (drive.ready),
    .digit_enable (drive.digit_enable),
    .segments     (drive.segments),
    .point        (drive.point),
    .drive_valid  (drive.drive_valid)
);

`default_nettype wire

### verif/testbench.sv
// Self-checking testbench for the five-digit multiplexed seven-segment scanner.
`timescale 1ns / 100ps

module testbench
    import msss_pkg::*;
();

    localparam logic [REQ_W-1:0] REQ_SPARE = 2'd3;

    typedef struct packed {
        logic [NUM_DIGITS-1:0] digit_enable;
        logic [SEG_W-1:0]      segments;
        logic                  point;
        logic                  indicator_off;
        logic                  drive_valid;
    } drive_t;

    logic clk = 1'b0;
    logic rst_n;

    msss_tick_if  tick ();
    msss_drive_if drive ();

    multiplexed_seven_segment_scanner_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .tick  (tick),
        .drive (drive)
    );

    msss_item_t pending_ticks[$];
    drive_t     expected_drive[$];
    msss_item_t next_tick;
    int         total_ticks;
    int         accepted_ticks;
    int         fail_count;
    int         cycle_count;
    int         send_gap;
    int         stall_left;
    int         stall_len;

    logic [POS_W-1:0]      scan_pos = '0;
    logic [SEG_W-1:0]      held_seg = '0;
    logic                  held_pnt = 1'b0;
    logic                  held_ind = 1'b0;
    logic [NUM_DIGITS-1:0] held_den = '0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [SEG_W-1:0] glyph_of(input int code);
        case (code)
            0:       return 7'h3F;
            1:       return 7'h06;
            2:       return 7'h5B;
            3:       return 7'h4F;
            4:       return 7'h66;
            5:       return 7'h6D;
            6:       return 7'h7D;
            7:       return 7'h07;
            8:       return 7'h7F;
            9:       return 7'h6F;
            10:      return 7'h6F;
            11:      return 7'h7F;
            12:      return 7'h79;
            13:      return 7'h3F;
            14:      return 7'h79;
            15:      return 7'h71;
            16:      return 7'h01;
            17:      return 7'h38;
            18:      return 7'h3E;
            default: return 7'h00;
        endcase
    endfunction

    function automatic drive_t scan_tick(input msss_item_t t);
        logic               active;
        logic [IDX_W-1:0]   idx;
        logic [VALUE_W-1:0] shown;
        logic [CODE_W-1:0]  code;
        int                 weight;
        int                 digit;
        drive_t             r;
        active = (scan_pos >= POS_FIRST) && (scan_pos <= POS_LAST);
        idx = active ? IDX_W'(scan_pos - POS_FIRST) : '0;
        shown = (t.value > VALUE_MAX) ? VALUE_MAX : t.value;
        weight = 1;
        repeat (NUM_DIGITS - 1 - int'(idx)) weight = weight * 10;
        digit = (int'(shown) / weight) % 10;
        case (t.req_type) inside
            REQ_NUMBER:
            begin
                held_ind = 1'b0;
                if (active)
                begin
                    held_seg = glyph_of(digit);
                    held_pnt = (idx == 3'd2) ? t.dot : 1'b0;
                    held_den = (idx == 3'd0 && digit == 0) ? '0 : NUM_DIGITS'(1) << idx;
                end
            end
            REQ_OFF, REQ_BT:
            begin
                if (t.req_type == REQ_BT)
                    held_ind = 1'b1;
                if (active)
                begin
                    code = CODE_NONE;
                    if (t.req_type == REQ_OFF)
                    begin
                        case (idx) inside
                            3'd2:       code = CODE_O;
                            3'd3, 3'd4: code = CODE_F;
                            default:    code = CODE_NONE;
                        endcase
                    end
                    else
                    begin
                        case (idx)
                            3'd1:    code = CODE_8;
                            3'd2:    code = CODE_L;
                            3'd3:    code = CODE_U;
                            3'd4:    code = CODE_E;
                            default: code = CODE_NONE;
                        endcase
                    end
                    if (code == CODE_NONE)
                        held_den = '0;
                    else
                    begin
                        held_den = NUM_DIGITS'(1) << idx;
                        held_seg = glyph_of(int'(code));
                        held_pnt = 1'b0;
                    end
                end
            end
            default:
            begin
            end
        endcase
        scan_pos = (scan_pos >= POS_LAST) ? POS_FIRST : scan_pos + POS_W'(1);
        r.digit_enable  = held_den;
        r.segments      = held_seg;
        r.point         = held_pnt;
        r.indicator_off = held_ind;
        r.drive_valid   = active;
        return r;
    endfunction

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if ((cycle_count % 600) < 120 || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [VALUE_W-1:0] rand_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return VALUE_W'($urandom_range(0, 99999));
        if (r < 80)
            return VALUE_W'($urandom_range(0, 9999));
        if (r < 92)
            return VALUE_W'($urandom_range(100000, 131071));
        return VALUE_W'($urandom);
    endfunction

    task automatic add_tick(input logic [REQ_W-1:0] req, input logic [VALUE_W-1:0] val,
                            input logic dot);
        msss_item_t t;
        t.req_type = req;
        t.value    = val;
        t.dot      = dot;
        pending_ticks.push_back(t);
        total_ticks++;
    endtask

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick.valid    <= 1'b0;
            tick.req_type <= '0;
            tick.value    <= '0;
            tick.dot      <= 1'b0;
            send_gap      <= 0;
        end
        else if (!tick.valid || tick.ready)
        begin
            if (send_gap != 0 || pending_ticks.size() == 0)
            begin
                tick.valid <= 1'b0;
                if (send_gap != 0)
                    send_gap <= send_gap - 1;
            end
            else
            begin
                next_tick = pending_ticks.pop_front();
                tick.valid    <= 1'b1;
                tick.req_type <= next_tick.req_type;
                tick.value    <= next_tick.value;
                tick.dot      <= next_tick.dot;
                send_gap      <= idle_len();
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drive.ready <= 1'b0;
            stall_left  <= 0;
        end
        else if (stall_left != 0)
        begin
            drive.ready <= 1'b0;
            stall_left  <= stall_left - 1;
        end
        else
        begin
            stall_len = idle_len();
            drive.ready <= (stall_len == 0);
            stall_left  <= (stall_len == 0) ? 0 : stall_len - 1;
        end
    end

    always @(posedge clk)
    begin
        drive_t want;
        drive_t got;
        if (rst_n)
        begin
            if (tick.valid && tick.ready)
            begin
                expected_drive.push_back(scan_tick('{tick.req_type, tick.value, tick.dot}));
                accepted_ticks++;
            end
            if (drive.valid && drive.ready)
            begin
                got = '{drive.digit_enable, drive.segments, drive.point,
                        drive.indicator_off, drive.drive_valid};
                if (expected_drive.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("%0t: drive transfer with nothing expected: %h", $time, got);
                    fail_count++;
                end
                else
                begin
                    want = expected_drive.pop_front();
                    if (got.digit_enable !== want.digit_enable
                        || got.segments !== want.segments
                        || got.point !== want.point
                        || got.indicator_off !== want.indicator_off
                        || got.drive_valid !== want.drive_valid)
                    begin
                        if (fail_count < 10)
                            $display({"%0t: drive mismatch: expected en=%b seg=%h pt=%b ind=%b ",
                                      "dv=%b, got en=%b seg=%h pt=%b ind=%b dv=%b"}, $time,
                                     want.digit_enable, want.segments, want.point,
                                     want.indicator_off, want.drive_valid, got.digit_enable,
                                     got.segments, got.point, got.indicator_off,
                                     got.drive_valid);
                        fail_count++;
                    end
                end
            end
        end
    end

    initial
    begin
        logic [REQ_W-1:0]   req;
        logic [VALUE_W-1:0] val;
        logic               dot;
        int                 r;
        rst_n         = 1'b0;
        tick.valid    = 1'b0;
        tick.req_type = '0;
        tick.value    = '0;
        tick.dot      = 1'b0;
        drive.ready   = 1'b0;

        // The first tick after reset drives nothing but still raises the indicator.
        add_tick(REQ_BT, 17'd0, 1'b0);
        repeat (5) add_tick(REQ_NUMBER, 17'h1FFFF, 1'b1);
        repeat (5) add_tick(REQ_NUMBER, 17'd0, 1'b0);
        repeat (5) add_tick(REQ_OFF, 17'd54321, 1'b1);
        repeat (5) add_tick(REQ_BT, 17'd99999, 1'b1);
        add_tick(REQ_SPARE, 17'h10000, 1'b1);
        add_tick(REQ_NUMBER, 17'd99999, 1'b1);
        add_tick(REQ_NUMBER, 17'd100000, 1'b0);
        add_tick(REQ_NUMBER, 17'd1234, 1'b1);

        while (total_ticks < 450)
        begin
            r = $urandom_range(0, 9);
            if (r < 7)
            begin
                r = $urandom_range(0, 9);
                req = (r < 6) ? REQ_NUMBER : (r < 8) ? REQ_OFF : REQ_BT;
                val = rand_value();
                dot = 1'($urandom_range(0, 1));
                repeat (NUM_DIGITS) add_tick(req, val, dot);
            end
            else
            begin
                repeat ($urandom_range(1, 3))
                    add_tick(REQ_W'($urandom_range(0, 3)), rand_value(),
                             1'($urandom_range(0, 1)));
            end
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (accepted_ticks != total_ticks)
            @(posedge clk);
        while (expected_drive.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (fail_count == 0 && expected_drive.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
